### rtl/fmlf_pkg.sv
package fmlf_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int MAX_BYTES = 1048576;
   localparam int PAT_IDX_W = $clog2(MAX_PATTERN);
   localparam int PAT_LEN_W = 5;
   localparam int OFS_W = 20;
   localparam int POS_W = 21;
   localparam int LEN_W = 21;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [7:0] NEWLINE_CODE = 8'h0a;

   localparam logic [1:0] REG_PATTERN_LOW = 2'd0;
   localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
   localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

   typedef struct packed {
      logic [MAX_PATTERN-1:0][7:0] pattern;
      logic [PAT_LEN_W-1:0] length;
   } cfg_type;

   typedef struct packed {
      logic equal;
      logic [OFS_W-1:0] line_start;
   } match_type;

endpackage

### rtl/fmlf_csr.sv
module fmlf_csr (
   input logic clock,
   input logic reset,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [fmlf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [fmlf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fmlf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output fmlf_pkg::cfg_type cfg
);

   logic [63:0] pat_low_ff, pat_low_in;
   logic [63:0] pat_high_ff, pat_high_in;
   logic [fmlf_pkg::PAT_LEN_W-1:0] pat_len_ff, pat_len_in;
   logic wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx = csr_paddr[4:3];

   always_comb begin
      pat_low_in = pat_low_ff;
      pat_high_in = pat_high_ff;
      pat_len_in = pat_len_ff;
      if (wr_en) begin
         case (reg_idx)
            fmlf_pkg::REG_PATTERN_LOW: pat_low_in = csr_pwdata;
            fmlf_pkg::REG_PATTERN_HIGH: pat_high_in = csr_pwdata;
            fmlf_pkg::REG_PATTERN_LENGTH: pat_len_in = csr_pwdata[fmlf_pkg::PAT_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff <= '0;
         pat_high_ff <= '0;
         pat_len_ff <= fmlf_pkg::PAT_LEN_W'(1);
      end else begin
         pat_low_ff <= pat_low_in;
         pat_high_ff <= pat_high_in;
         pat_len_ff <= pat_len_in;
      end
   end

   always_comb begin
      case (reg_idx)
         fmlf_pkg::REG_PATTERN_LOW: csr_prdata = pat_low_ff;
         fmlf_pkg::REG_PATTERN_HIGH: csr_prdata = pat_high_ff;
         fmlf_pkg::REG_PATTERN_LENGTH:
            csr_prdata = fmlf_pkg::CSR_DATA_W'(pat_len_ff);
         default: csr_prdata = '0;
      endcase
   end

   // zero acts as one, anything above the maximum acts as the maximum
   always_comb begin
      cfg.pattern = {pat_high_ff, pat_low_ff};
      if (pat_len_ff == '0) begin
         cfg.length = fmlf_pkg::PAT_LEN_W'(1);
      end else if (pat_len_ff > fmlf_pkg::PAT_LEN_W'(fmlf_pkg::MAX_PATTERN)) begin
         cfg.length = fmlf_pkg::PAT_LEN_W'(fmlf_pkg::MAX_PATTERN);
      end else begin
         cfg.length = pat_len_ff;
      end
   end

endmodule

### rtl/fmlf_window.sv
module fmlf_window (
   input logic clock,
   input logic shift_en,
   input logic [7:0] byte_value,
   input logic [fmlf_pkg::OFS_W-1:0] cur_line_start,
   input fmlf_pkg::cfg_type cfg,
   output fmlf_pkg::match_type match
);

   logic [7:0] byte_ff [fmlf_pkg::MAX_PATTERN];
   logic [fmlf_pkg::OFS_W-1:0] ls_ff [fmlf_pkg::MAX_PATTERN];
   logic [7:0] view [fmlf_pkg::MAX_PATTERN];
   logic [fmlf_pkg::MAX_PATTERN-1:0] hit;
   logic [fmlf_pkg::PAT_LEN_W-1:0] pidx;
   logic [fmlf_pkg::PAT_LEN_W-1:0] lidx;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff[0] <= byte_value;
         ls_ff[0] <= cur_line_start;
         for (int k = 1; k < fmlf_pkg::MAX_PATTERN; k++) begin
            byte_ff[k] <= byte_ff[k-1];
            ls_ff[k] <= ls_ff[k-1];
         end
      end
   end

   // window as it stands once the incoming byte is shifted in
   always_comb begin
      view[0] = byte_value;
      for (int k = 1; k < fmlf_pkg::MAX_PATTERN; k++) begin
         view[k] = byte_ff[k-1];
      end
   end

   always_comb begin
      hit = '0;
      pidx = '0;
      for (int j = 0; j < fmlf_pkg::MAX_PATTERN; j++) begin
         pidx = cfg.length - fmlf_pkg::PAT_LEN_W'(j + 1);
         if (fmlf_pkg::PAT_LEN_W'(j) >= cfg.length) begin
            hit[j] = 1'b1;
         end else begin
            hit[j] = (view[j] == cfg.pattern[pidx[fmlf_pkg::PAT_IDX_W-1:0]]);
         end
      end
   end

   assign lidx = cfg.length - fmlf_pkg::PAT_LEN_W'(2);

   always_comb begin
      match.equal = &hit;
      if (cfg.length == fmlf_pkg::PAT_LEN_W'(1)) begin
         match.line_start = cur_line_start;
      end else begin
         match.line_start = ls_ff[lidx[fmlf_pkg::PAT_IDX_W-1:0]];
      end
   end

endmodule

### rtl/first_match_line_finder_core.sv
// Streams a buffer in one byte per transfer and reports, once per buffer, the
// leftmost occurrence of the programmed pattern (1 to 16 bytes) together with
// the start and length of the line that holds it. The result is sent when the
// newline closing that line arrives, or with the transfer flagged last_byte
// when no result has gone out yet; a buffer without a match reports found=0.
// A byte is taken every cycle while the result register is empty or its result
// is taken in that cycle. Each byte is held in an input register while a 16-way
// parallel compare of the byte window against the pattern runs on it, and the
// result register loads from it when the byte leaves the input register. A
// stalled result holds the input register and then the input.
// Positions saturate at 1048576 bytes and set overflow. Program the pattern
// registers only while no buffer is in flight.
module first_match_line_finder_core (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [7:0] req_byte_value,
   input logic req_last_byte,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic rsp_found,
   output logic [19:0] rsp_match_offset,
   output logic [19:0] rsp_line_start,
   output logic [20:0] rsp_line_length,
   output logic rsp_overflow,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [fmlf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [fmlf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fmlf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int OW = fmlf_pkg::OFS_W;
   localparam int PW = fmlf_pkg::POS_W;

   fmlf_pkg::cfg_type cfg;
   fmlf_pkg::match_type match;

   logic s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic s1_last_ff;

   logic [PW-1:0] pos_ff, pos_in;
   logic [OW-1:0] cur_ls_ff, cur_ls_in;
   logic seen_ff, seen_in;
   logic [OW-1:0] ofs_ff, ofs_in;
   logic [OW-1:0] mls_ff, mls_in;
   logic reported_ff, reported_in;
   logic ovf_ff, ovf_in;

   logic out_valid_ff, out_valid_in;
   logic out_found_ff, out_found_in;
   logic [OW-1:0] out_ofs_ff, out_ofs_in;
   logic [OW-1:0] out_ls_ff, out_ls_in;
   logic [fmlf_pkg::LEN_W-1:0] out_len_ff, out_len_in;
   logic out_ovf_ff, out_ovf_in;

   logic out_free, advance, in_range, shift_en, try_cmp, just_hit, is_nl;
   logic emit_nl, emit_last;
   logic [PW-1:0] pos_inc, start_wide;
   logic [PW-1:0] line_end;

   fmlf_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   fmlf_window u_window (
      .clock(clock),
      .shift_en(shift_en),
      .byte_value(s1_byte_ff),
      .cur_line_start(cur_ls_ff),
      .cfg(cfg),
      .match(match)
   );

   assign out_free = !out_valid_ff || rsp_ready;
   assign advance = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_byte_value;
         s1_last_ff <= req_last_byte;
      end
   end

   assign in_range = pos_ff < PW'(fmlf_pkg::MAX_BYTES);
   assign shift_en = advance && in_range;
   assign pos_inc = pos_ff + PW'(1);
   assign is_nl = s1_byte_ff == fmlf_pkg::NEWLINE_CODE;
   assign try_cmp = !seen_ff && !reported_ff && (pos_inc >= PW'(cfg.length));
   assign just_hit = shift_en && try_cmp && match.equal;
   assign emit_nl = shift_en && seen_ff && !reported_ff && is_nl;
   assign emit_last = advance && s1_last_ff && !reported_ff && !emit_nl;
   assign start_wide = pos_inc - PW'(cfg.length);

   always_comb begin
      pos_in = pos_ff;
      cur_ls_in = cur_ls_ff;
      seen_in = seen_ff;
      ofs_in = ofs_ff;
      mls_in = mls_ff;
      reported_in = reported_ff;
      ovf_in = ovf_ff;
      if (advance) begin
         if (!in_range) begin
            ovf_in = 1'b1;
         end else begin
            pos_in = pos_inc;
            if (is_nl) begin
               cur_ls_in = pos_inc[OW-1:0];
            end
         end
         if (just_hit) begin
            seen_in = 1'b1;
            ofs_in = start_wide[OW-1:0];
            mls_in = match.line_start;
         end
         if (emit_nl) begin
            reported_in = 1'b1;
         end
         if (s1_last_ff) begin
            pos_in = '0;
            cur_ls_in = '0;
            seen_in = 1'b0;
            ofs_in = '0;
            mls_in = '0;
            reported_in = 1'b0;
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cur_ls_ff <= '0;
         seen_ff <= 1'b0;
         ofs_ff <= '0;
         mls_ff <= '0;
         reported_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         cur_ls_ff <= cur_ls_in;
         seen_ff <= seen_in;
         ofs_ff <= ofs_in;
         mls_ff <= mls_in;
         reported_ff <= reported_in;
         ovf_ff <= ovf_in;
      end
   end

   // result fields, built from the buffer state and the byte now advancing
   always_comb begin
      line_end = emit_nl ? pos_ff : (in_range ? pos_inc : pos_ff);
      out_valid_in = out_valid_ff;
      out_found_in = out_found_ff;
      out_ofs_in = out_ofs_ff;
      out_ls_in = out_ls_ff;
      out_len_in = out_len_ff;
      out_ovf_in = out_ovf_ff;
      if (emit_nl || emit_last) begin
         out_valid_in = 1'b1;
         out_ovf_in = ovf_ff || !in_range;
         if (seen_ff || just_hit) begin
            out_found_in = 1'b1;
            out_ofs_in = just_hit ? start_wide[OW-1:0] : ofs_ff;
            out_ls_in = just_hit ? match.line_start : mls_ff;
            out_len_in = line_end - PW'(just_hit ? match.line_start : mls_ff);
         end else begin
            out_found_in = 1'b0;
            out_ofs_in = '0;
            out_ls_in = '0;
            out_len_in = '0;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_found_ff <= out_found_in;
      out_ofs_ff <= out_ofs_in;
      out_ls_ff <= out_ls_in;
      out_len_ff <= out_len_in;
      out_ovf_ff <= out_ovf_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_found = out_found_ff;
   assign rsp_match_offset = out_ofs_ff;
   assign rsp_line_start = out_ls_ff;
   assign rsp_line_length = out_len_ff;
   assign rsp_overflow = out_ovf_ff;

endmodule

### rtl/fmlf_checker.sv
module fmlf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [7:0] req_byte_value,
   input logic req_last_byte,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_found,
   input logic [19:0] rsp_match_offset,
   input logic [19:0] rsp_line_start,
   input logic [20:0] rsp_line_length,
   input logic rsp_overflow,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [fmlf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [fmlf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [fmlf_pkg::CSR_DATA_W-1:0] csr_prdata,
   input logic csr_pready
);

   // a stalled result holds its found flag, match offset and line length
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_match_offset) && $stable(rsp_line_length))
      else $error("result changed while stalled");

   // not found reports all position fields as zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == '0 && rsp_line_start == '0
         && rsp_line_length == '0)
      else $error("miss result carries nonzero fields");

   // the matching line begins at or before the match
   a_line_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_line_start <= rsp_match_offset)
      else $error("line start after match offset");

   // a write to the low pattern register reads back on the next cycle at the same address
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
         && csr_paddr[4:3] == fmlf_pkg::REG_PATTERN_LOW
      ##1 csr_paddr == $past(csr_paddr) |-> csr_prdata == $past(csr_pwdata))
      else $error("pattern register readback mismatch");

endmodule

bind first_match_line_finder_core fmlf_checker u_fmlf_checker (.*);
